// ===== src/rlc_pkg.sv =====
// shared types and constants for the resolving list with lru cache
`default_nettype none
package rlc_pkg;

  localparam int DEF_TABLE_SLOTS = 16;
  localparam int DEF_CACHE_LINES = 8;
  localparam int ADDR_W          = 48;
  localparam int KEY_W           = 64;
  localparam int IDX_W           = 4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_KEY = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [2:0] {
    MODE_ADD    = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_CLEAR  = 3'd2,
    MODE_LOOKUP = 3'd3,
    MODE_RECORD = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOT_SEED,
    S_SLOT_SCAN,
    S_SLOT_WRITE,
    S_LINE_SEED,
    S_LINE_SCAN,
    S_LINE_UPDATE,
    S_DONE
  } rlc_state_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic              peer_type;
    logic [ADDR_W-1:0] address_in;
    logic [KEY_W-1:0]  irk_high;
    logic [KEY_W-1:0]  irk_low;
    logic              identity_valid;
    logic [IDX_W-1:0]  identity_index;
  } rlc_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              hit;
    logic              has_identity;
    logic              identity_type;
    logic [ADDR_W-1:0] identity_address;
    logic [4:0]        list_count;
    logic              restart_needed;
  } rlc_out_t;

  typedef struct packed {
    logic              adv;
    logic              seed;
    logic              free;
    logic              clear;
    logic              wr_en;
    logic              peer_type;
    logic [ADDR_W-1:0] address;
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
  } slot_cmd_t;

  typedef struct packed {
    logic              used;
    logic              id_match;
    logic              key_match;
    logic              peer_type;
    logic [ADDR_W-1:0] address;
  } slot_rep_t;

  typedef struct packed {
    logic              adv;
    logic              seed;
    logic              kill;
    logic              promote;
    logic              record;
    logic              rec_resolved;
    logic [IDX_W-1:0]  rec_slot;
    logic [ADDR_W-1:0] address;
  } line_cmd_t;

  typedef struct packed {
    logic             valid;
    logic             addr_match;
    logic             resolved;
    logic [IDX_W-1:0] slot;
  } line_rep_t;

endpackage
`default_nettype wire

// ===== src/rlc_slot_cell.sv =====
// one identity slot of the table, scanned by a token passed along the chain
`default_nettype none
module rlc_slot_cell import rlc_pkg::*; #(
  parameter int SW  = 4,
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          tok_in,
  output logic               tok_out,
  input  wire slot_cmd_t     cmd,
  input  wire logic [SW-1:0] wr_idx,
  output slot_rep_t          rep
);

  logic              tok_r;
  logic              used_r;
  logic              type_r;
  logic [ADDR_W-1:0] addr_r;
  logic [KEY_W-1:0]  khi_r;
  logic [KEY_W-1:0]  klo_r;
  logic              wr_hit;

  assign wr_hit  = cmd.wr_en && (wr_idx == SW'(IDX));
  assign tok_out = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= 1'b0;
      used_r <= 1'b0;
    end else begin
      if (cmd.adv) begin
        tok_r <= tok_in;
      end
      if (cmd.clear) begin
        used_r <= 1'b0;
      end else if (wr_hit) begin
        used_r <= 1'b1;
      end else if (cmd.free && tok_r) begin
        used_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      type_r <= cmd.peer_type;
      addr_r <= cmd.address;
      khi_r  <= cmd.key_high;
      klo_r  <= cmd.key_low;
    end
  end

  always_comb begin
    rep = '0;
    if (tok_r) begin
      rep.used      = used_r;
      rep.id_match  = (type_r == cmd.peer_type) && (addr_r == cmd.address);
      rep.key_match = (khi_r == cmd.key_high) && (klo_r == cmd.key_low);
      rep.peer_type = type_r;
      rep.address   = addr_r;
    end
  end

endmodule
`default_nettype wire

// ===== src/rlc_line_cell.sv =====
// one cache line with its lru age, scanned by a token passed along the chain
`default_nettype none
module rlc_line_cell import rlc_pkg::*; #(
  parameter int LW  = 3,
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          tok_in,
  output logic               tok_out,
  input  wire line_cmd_t     cmd,
  input  wire logic [LW-1:0] kill_age,
  input  wire logic [LW-1:0] promo_age,
  input  wire logic [LW-1:0] sel_idx,
  output line_rep_t          rep,
  output logic [LW-1:0]      rep_age
);

  logic              tok_r;
  logic              valid_r;
  logic [ADDR_W-1:0] addr_r;
  logic              res_r;
  logic [IDX_W-1:0]  slot_r;
  logic [LW-1:0]     age_r;
  logic              sel;

  assign sel     = (sel_idx == LW'(IDX));
  assign tok_out = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= 1'b0;
      valid_r <= 1'b0;
      age_r   <= '0;
    end else begin
      if (cmd.adv) begin
        tok_r <= tok_in;
      end
      if (cmd.kill) begin
        if (tok_r) begin
          valid_r <= 1'b0;
          age_r   <= '0;
        end else if (valid_r && (age_r > kill_age)) begin
          age_r <= age_r - 1'b1;
        end
      end else if (cmd.promote) begin
        if (sel) begin
          age_r <= '0;
        end else if (valid_r && (age_r < promo_age)) begin
          age_r <= age_r + 1'b1;
        end
      end else if (cmd.record) begin
        if (sel) begin
          valid_r <= 1'b1;
          age_r   <= '0;
        end else if (valid_r) begin
          age_r <= age_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.record && sel) begin
      addr_r <= cmd.address;
      res_r  <= cmd.rec_resolved;
      slot_r <= cmd.rec_slot;
    end
  end

  always_comb begin
    rep     = '0;
    rep_age = '0;
    if (tok_r) begin
      rep.valid      = valid_r;
      rep.addr_match = (addr_r == cmd.address);
      rep.resolved   = res_r;
      rep.slot       = slot_r;
      rep_age        = age_r;
    end
  end

endmodule
`default_nettype wire

// ===== src/resolving_list_with_lru_cache_top.sv =====
// top level: identity table chain, cache line chain and the command sequencer
// One command at a time: busy is high from the accepting edge until the result
// beat. A command walks a token along the slot chain and/or the line chain, one
// cell per cycle, after a seed step for each walk. An add with the key set scans
// the slots and, with no duplicate and a free slot, writes it and walks the lines;
// a remove walks the slots, then the lines; a record walks the slots and lines and
// then updates a line; a clear empties the table and walks the lines; a lookup
// walks the lines and, on a hit, promotes that line and walks the slots again if
// it is resolved. A refused add without a key or an unused mode goes straight to
// the result; busy drops the cycle after the result beat. out_valid is high for
// exactly one cycle and the result must be taken then: there is no back-pressure.
`default_nettype none
module resolving_list_with_lru_cache_top import rlc_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int CACHE_LINES = DEF_CACHE_LINES
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire rlc_in_t in_item,
  output logic         out_valid,
  output rlc_out_t     out_res,
  input  wire logic    cfg_we,
  input  wire logic    cfg_wdata
);

  localparam int SW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int LW    = $clog2(CACHE_LINES);
  localparam int CNT_W = (SW > LW) ? SW : LW;
  localparam int IW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int CW    = $clog2(TABLE_SLOTS + 1);

  rlc_state_t state_r, state_nxt;
  rlc_in_t    item_r;
  logic       lkv_r;
  logic [CW-1:0]    count_r;
  logic [CNT_W-1:0] cnt_r;

  logic [1:0]        status_r;
  logic              hit_r;
  logic              hasid_r;
  logic              idtype_r;
  logic [ADDR_W-1:0] idaddr_r;
  logic              restart_r;

  logic                   dup_r;
  logic                   free_found_r;
  logic [SW-1:0]          free_idx_r;
  logic [TABLE_SLOTS-1:0] freed_r;
  logic                   used_cap_r;
  logic                   found_r;
  logic [LW-1:0]          best_age_r;
  logic [LW-1:0]          best_idx_r;
  logic                   best_res_r;
  logic [IDX_W-1:0]       best_slot_r;
  logic                   inv_found_r;
  logic [LW-1:0]          inv_idx_r;
  logic [LW-1:0]          evict_idx_r;

  slot_cmd_t scmd;
  line_cmd_t lcmd;
  slot_rep_t srep_a [TABLE_SLOTS];
  line_rep_t lrep_a [CACHE_LINES];
  logic [LW-1:0] lage_a [CACHE_LINES];
  slot_rep_t srep;
  line_rep_t lrep;
  logic [LW-1:0] lrep_age;
  logic [TABLE_SLOTS:0] stok;
  logic [CACHE_LINES:0] ltok;

  logic slot_last, line_last;
  logic dup_hit, dup_now, free_now, lmatch, found_now, freed_hit, kill_cond;
  logic [LW-1:0] pick_idx, sel_idx;

  // chains
  assign stok[0] = scmd.seed;
  assign ltok[0] = lcmd.seed;

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_slot
    rlc_slot_cell #(.SW(SW), .IDX(i)) u_slot (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_in (stok[i]),
      .tok_out(stok[i+1]),
      .cmd    (scmd),
      .wr_idx (free_idx_r),
      .rep    (srep_a[i])
    );
  end

  for (genvar i = 0; i < CACHE_LINES; i++) begin : g_line
    rlc_line_cell #(.LW(LW), .IDX(i)) u_line (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (ltok[i]),
      .tok_out  (ltok[i+1]),
      .cmd      (lcmd),
      .kill_age (lrep_age),
      .promo_age(best_age_r),
      .sel_idx  (sel_idx),
      .rep      (lrep_a[i]),
      .rep_age  (lage_a[i])
    );
  end

  always_comb begin
    srep = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      srep = srep | srep_a[i];
    end
  end

  always_comb begin
    lrep     = '0;
    lrep_age = '0;
    for (int i = 0; i < CACHE_LINES; i++) begin
      lrep     = lrep | lrep_a[i];
      lrep_age = lrep_age | lage_a[i];
    end
  end

  assign slot_last = stok[TABLE_SLOTS];
  assign line_last = ltok[CACHE_LINES];
  assign dup_hit   = srep.used && srep.id_match && srep.key_match;
  assign dup_now   = dup_r || dup_hit;
  assign free_now  = free_found_r || !srep.used;
  assign lmatch    = lrep.valid && lrep.addr_match;
  assign found_now = found_r || lmatch;
  assign pick_idx  = inv_found_r ? inv_idx_r : evict_idx_r;
  assign sel_idx   = (item_r.mode == MODE_LOOKUP) ? best_idx_r : pick_idx;

  always_comb begin
    freed_hit = 1'b0;
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      if (freed_r[k] && (IW'(lrep.slot) == IW'(k))) begin
        freed_hit = 1'b1;
      end
    end
  end

  always_comb begin
    case (item_r.mode)
      MODE_ADD:    kill_cond = lrep.valid && !lrep.resolved;
      MODE_REMOVE: kill_cond = lrep.valid && lrep.resolved && freed_hit;
      MODE_CLEAR:  kill_cond = lrep.valid && lrep.resolved;
      default:     kill_cond = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_item.mode)
            MODE_ADD:    state_nxt = lkv_r ? S_SLOT_SEED : S_DONE;
            MODE_REMOVE: state_nxt = S_SLOT_SEED;
            MODE_RECORD: state_nxt = S_SLOT_SEED;
            MODE_CLEAR:  state_nxt = S_SLOT_WRITE;
            MODE_LOOKUP: state_nxt = S_LINE_SEED;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_SLOT_SEED: state_nxt = S_SLOT_SCAN;
      S_SLOT_SCAN: begin
        if (slot_last) begin
          case (item_r.mode)
            MODE_ADD:    state_nxt = (dup_now || !free_now) ? S_DONE : S_SLOT_WRITE;
            MODE_REMOVE: state_nxt = S_LINE_SEED;
            MODE_RECORD: state_nxt = S_LINE_SEED;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_SLOT_WRITE: state_nxt = S_LINE_SEED;
      S_LINE_SEED:  state_nxt = S_LINE_SCAN;
      S_LINE_SCAN: begin
        if (line_last) begin
          case (item_r.mode)
            MODE_LOOKUP: state_nxt = found_now ? S_LINE_UPDATE : S_DONE;
            MODE_RECORD: state_nxt = S_LINE_UPDATE;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_LINE_UPDATE: begin
        state_nxt = ((item_r.mode == MODE_LOOKUP) && best_res_r) ? S_SLOT_SEED : S_DONE;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // outputs and cell commands
  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);

    scmd           = '0;
    scmd.adv       = (state_r == S_SLOT_SEED) || (state_r == S_SLOT_SCAN);
    scmd.seed      = (state_r == S_SLOT_SEED);
    scmd.free      = (state_r == S_SLOT_SCAN) && (item_r.mode == MODE_REMOVE) &&
                     srep.used && srep.id_match;
    scmd.clear     = (state_r == S_SLOT_WRITE) && (item_r.mode == MODE_CLEAR);
    scmd.wr_en     = (state_r == S_SLOT_WRITE) && (item_r.mode == MODE_ADD);
    scmd.peer_type = item_r.peer_type;
    scmd.address   = item_r.address_in;
    scmd.key_high  = item_r.irk_high;
    scmd.key_low   = item_r.irk_low;

    lcmd              = '0;
    lcmd.adv          = (state_r == S_LINE_SEED) || (state_r == S_LINE_SCAN);
    lcmd.seed         = (state_r == S_LINE_SEED);
    lcmd.kill         = (state_r == S_LINE_SCAN) && kill_cond;
    lcmd.promote      = (state_r == S_LINE_UPDATE) && (item_r.mode == MODE_LOOKUP);
    lcmd.record       = (state_r == S_LINE_UPDATE) && (item_r.mode == MODE_RECORD);
    lcmd.rec_resolved = item_r.identity_valid && used_cap_r;
    lcmd.rec_slot     = lcmd.rec_resolved ? item_r.identity_index : '0;
    lcmd.address      = item_r.address_in;

    out_res                  = '0;
    out_res.status           = status_r;
    out_res.hit              = hit_r;
    out_res.has_identity     = hasid_r;
    out_res.identity_type    = idtype_r;
    out_res.identity_address = idaddr_r;
    out_res.list_count       = 5'(count_r);
    out_res.restart_needed   = restart_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lkv_r   <= 1'b0;
      count_r <= '0;
    end else begin
      if (cfg_we) begin
        lkv_r <= cfg_wdata;
      end
      if ((state_r == S_SLOT_SCAN) && scmd.free) begin
        count_r <= count_r - 1'b1;
      end else if (scmd.wr_en) begin
        count_r <= count_r + 1'b1;
      end else if (scmd.clear) begin
        count_r <= '0;
      end
    end
  end

  // per-command working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_r       <= in_item;
          status_r     <= ((in_item.mode == MODE_ADD) && !lkv_r) ? ST_NO_KEY : ST_OK;
          hit_r        <= 1'b0;
          hasid_r      <= 1'b0;
          idtype_r     <= 1'b0;
          idaddr_r     <= '0;
          restart_r    <= 1'b0;
          dup_r        <= 1'b0;
          free_found_r <= 1'b0;
          freed_r      <= '0;
          used_cap_r   <= 1'b0;
          found_r      <= 1'b0;
          inv_found_r  <= 1'b0;
        end
      end
      S_SLOT_SEED: cnt_r <= '0;
      S_SLOT_SCAN: begin
        cnt_r <= cnt_r + 1'b1;
        case (item_r.mode)
          MODE_ADD: begin
            if (dup_hit) begin
              dup_r <= 1'b1;
            end
            if (!srep.used && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= cnt_r[SW-1:0];
            end
            if (slot_last && !dup_now && !free_now) begin
              status_r <= ST_FULL;
            end
          end
          MODE_REMOVE: begin
            if (scmd.free) begin
              freed_r[cnt_r[SW-1:0]] <= 1'b1;
              restart_r              <= 1'b1;
            end
          end
          MODE_RECORD: begin
            if (IW'(cnt_r) == IW'(item_r.identity_index)) begin
              used_cap_r <= srep.used;
            end
          end
          MODE_LOOKUP: begin
            if (IW'(cnt_r) == IW'(best_slot_r)) begin
              hasid_r  <= 1'b1;
              idtype_r <= srep.peer_type;
              idaddr_r <= srep.address;
            end
          end
          default: ;
        endcase
      end
      S_SLOT_WRITE: restart_r <= 1'b1;
      S_LINE_SEED:  cnt_r <= '0;
      S_LINE_SCAN: begin
        cnt_r <= cnt_r + 1'b1;
        case (item_r.mode)
          MODE_LOOKUP: begin
            if (lmatch && (!found_r || (lrep_age < best_age_r))) begin
              found_r     <= 1'b1;
              best_age_r  <= lrep_age;
              best_idx_r  <= cnt_r[LW-1:0];
              best_res_r  <= lrep.resolved;
              best_slot_r <= lrep.slot;
            end
          end
          MODE_RECORD: begin
            if (!lrep.valid && !inv_found_r) begin
              inv_found_r <= 1'b1;
              inv_idx_r   <= cnt_r[LW-1:0];
            end
            if (lrep.valid && (lrep_age == LW'(CACHE_LINES - 1))) begin
              evict_idx_r <= cnt_r[LW-1:0];
            end
          end
          default: ;
        endcase
      end
      S_LINE_UPDATE: begin
        if (item_r.mode == MODE_LOOKUP) begin
          hit_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== tb/sv/rlc_checker.sv =====
// result checker: predicts each beat of the resolving list with lru cache and compares
`timescale 1ns / 1ps
`default_nettype none
module rlc_checker import rlc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     busy,
  input  wire rlc_in_t  in_item,
  input  wire logic     out_valid,
  input  wire rlc_out_t out_res,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata,
  output int            fail_count,
  output int            pending,
  output int            results_seen
);

  localparam int SLOTS = DEF_TABLE_SLOTS;
  localparam int LINES = DEF_CACHE_LINES;

  logic              key_set;
  logic              id_used [SLOTS];
  logic              id_type [SLOTS];
  logic [ADDR_W-1:0] id_addr [SLOTS];
  logic [KEY_W-1:0]  id_khi  [SLOTS];
  logic [KEY_W-1:0]  id_klo  [SLOTS];
  int                id_count;
  logic              ln_valid [LINES];
  logic [ADDR_W-1:0] ln_addr  [LINES];
  logic              ln_res   [LINES];
  logic [IDX_W-1:0]  ln_slot  [LINES];
  int                ln_age   [LINES];

  rlc_out_t expected_q[$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic void rerank_ages();
    int fresh [LINES];
    for (int i = 0; i < LINES; i++) begin
      fresh[i] = 0;
      if (ln_valid[i])
        for (int j = 0; j < LINES; j++)
          if (ln_valid[j] && ln_age[j] < ln_age[i]) fresh[i]++;
    end
    for (int i = 0; i < LINES; i++) ln_age[i] = ln_valid[i] ? fresh[i] : 0;
  endfunction

  // 0 unresolved, 1 resolved, 2 resolved to slot
  function automatic void purge_lines(input int what, input int slot);
    logic kill;
    for (int i = 0; i < LINES; i++) begin
      if (ln_valid[i]) begin
        if (what == 0) kill = !ln_res[i];
        else if (what == 1) kill = ln_res[i];
        else kill = ln_res[i] && ln_slot[i] == slot;
        if (kill) begin
          ln_valid[i] = 1'b0;
          ln_age[i] = 0;
        end
      end
    end
    rerank_ages();
  endfunction

  function automatic rlc_out_t resolve_request(input rlc_in_t it);
    rlc_out_t r;
    logic dup;
    int pick, found, oldest, a;
    logic resolved;
    r = '0;
    case (it.mode)
      MODE_ADD: begin
        if (!key_set) r.status = ST_NO_KEY;
        else begin
          dup = 1'b0;
          for (int i = 0; i < SLOTS; i++)
            if (id_used[i] && id_type[i] == it.peer_type && id_addr[i] == it.address_in &&
                id_khi[i] == it.irk_high && id_klo[i] == it.irk_low) dup = 1'b1;
          if (!dup) begin
            pick = -1;
            for (int i = 0; i < SLOTS; i++)
              if (!id_used[i] && pick < 0) pick = i;
            if (pick < 0) r.status = ST_FULL;
            else begin
              id_used[pick] = 1'b1;
              id_type[pick] = it.peer_type;
              id_addr[pick] = it.address_in;
              id_khi[pick] = it.irk_high;
              id_klo[pick] = it.irk_low;
              id_count++;
              purge_lines(0, 0);
              r.restart_needed = 1'b1;
            end
          end
        end
      end
      MODE_REMOVE: begin
        for (int i = 0; i < SLOTS; i++)
          if (id_used[i] && id_type[i] == it.peer_type && id_addr[i] == it.address_in) begin
            purge_lines(2, i);
            id_used[i] = 1'b0;
            if (id_count > 0) id_count--;
            r.restart_needed = 1'b1;
          end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) id_used[i] = 1'b0;
        purge_lines(1, 0);
        id_count = 0;
        r.restart_needed = 1'b1;
      end
      MODE_LOOKUP: begin
        found = -1;
        for (int i = 0; i < LINES; i++)
          if (ln_valid[i] && ln_addr[i] == it.address_in &&
              (found < 0 || ln_age[i] < ln_age[found])) found = i;
        if (found >= 0) begin
          a = ln_age[found];
          r.hit = 1'b1;
          if (ln_res[found]) begin
            r.has_identity = 1'b1;
            r.identity_type = id_type[ln_slot[found]];
            r.identity_address = id_addr[ln_slot[found]];
          end
          for (int i = 0; i < LINES; i++)
            if (ln_valid[i] && ln_age[i] < a) ln_age[i]++;
          ln_age[found] = 0;
        end
      end
      MODE_RECORD: begin
        resolved = it.identity_valid && id_used[it.identity_index];
        pick = -1;
        for (int i = 0; i < LINES; i++)
          if (!ln_valid[i] && pick < 0) pick = i;
        if (pick < 0) begin
          oldest = 0;
          pick = 0;
          for (int i = 0; i < LINES; i++)
            if (ln_age[i] >= oldest) begin
              oldest = ln_age[i];
              pick = i;
            end
          ln_valid[pick] = 1'b0;
        end
        for (int i = 0; i < LINES; i++)
          if (ln_valid[i]) ln_age[i]++;
        ln_valid[pick] = 1'b1;
        ln_addr[pick] = it.address_in;
        ln_res[pick] = resolved;
        ln_slot[pick] = resolved ? it.identity_index : '0;
        ln_age[pick] = 0;
        rerank_ages();
      end
      default: ;
    endcase
    r.list_count = id_count[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    rlc_out_t want;
    if (!rst_n) begin
      key_set <= 1'b0;
      id_count = 0;
      for (int i = 0; i < SLOTS; i++) id_used[i] = 1'b0;
      for (int i = 0; i < LINES; i++) begin
        ln_valid[i] = 1'b0;
        ln_age[i] = 0;
      end
      expected_q.delete();
      fail_count <= 0;
      results_seen <= 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) report("unexpected beat", out_res, 0);
        else begin
          want = expected_q.pop_front();
          if (out_res.status !== want.status) report("status", out_res.status, want.status);
          if (out_res.hit !== want.hit) report("hit", out_res.hit, want.hit);
          if (out_res.has_identity !== want.has_identity)
            report("has_identity", out_res.has_identity, want.has_identity);
          if (out_res.identity_type !== want.identity_type)
            report("identity_type", out_res.identity_type, want.identity_type);
          if (out_res.identity_address !== want.identity_address)
            report("identity_address", out_res.identity_address, want.identity_address);
          if (out_res.list_count !== want.list_count)
            report("list_count", out_res.list_count, want.list_count);
          if (out_res.restart_needed !== want.restart_needed)
            report("restart_needed", out_res.restart_needed, want.restart_needed);
        end
      end
      if (start && !busy) expected_q.push_back(resolve_request(in_item));
      pending <= expected_q.size();
      if (cfg_we) key_set <= cfg_wdata;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench top: clock, reset, stimulus and verdict for the resolving list with lru cache
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import rlc_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  rlc_in_t  in_item = '0;
  logic     out_valid;
  rlc_out_t out_res;
  logic     cfg_we = 1'b0;
  logic     cfg_wdata = 1'b0;
  int       fail_count, pending, results_seen;
  int       quiet_cycles = 0;
  int       beats_sent = 0;

  logic [ADDR_W-1:0] addr_pool [8];
  logic [KEY_W-1:0]  khi_pool [4];
  logic [KEY_W-1:0]  klo_pool [4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  resolving_list_with_lru_cache_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  rlc_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(input rlc_in_t it);
    while (busy) @(negedge clk);
    repeat ($urandom_range(0, 3)) @(negedge clk);
    in_item <= it;
    start <= 1'b1;
    @(negedge clk);
    start <= 1'b0;
    beats_sent++;
  endtask

  task automatic set_local_key(input logic v);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic rlc_in_t make_request(input logic [2:0] m, input int a, input int k);
    rlc_in_t it;
    it.mode = m;
    it.peer_type = 1'($urandom_range(0, 1));
    it.address_in = addr_pool[a];
    it.irk_high = khi_pool[k];
    it.irk_low = klo_pool[k];
    it.identity_valid = $urandom_range(0, 3) != 0;
    it.identity_index = IDX_W'($urandom_range(0, 15));
    return it;
  endfunction

  function automatic rlc_in_t random_request();
    rlc_in_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) it = make_request(MODE_ADD, $urandom_range(0, 7), $urandom_range(0, 3));
    else if (pick < 40) it = make_request(MODE_REMOVE, $urandom_range(0, 7), 0);
    else if (pick < 42) it = make_request(MODE_CLEAR, 0, 0);
    else if (pick < 67) it = make_request(MODE_LOOKUP, $urandom_range(0, 7), 0);
    else if (pick < 95) it = make_request(MODE_RECORD, $urandom_range(0, 7), 0);
    else begin
      it = make_request(3'($urandom_range(5, 7)), 0, 0);
      it.address_in = ADDR_W'({$urandom, $urandom});
    end
    if ($urandom_range(0, 9) == 0) begin
      it.address_in = ADDR_W'({$urandom, $urandom});
      it.irk_high = {$urandom, $urandom};
      it.irk_low = {$urandom, $urandom};
    end
    it.peer_type = (it.address_in[0] ^ it.address_in[47]) & 1'($urandom_range(0, 1));
    return it;
  endfunction

  initial begin
    rlc_in_t it;
    for (int i = 0; i < 8; i++) addr_pool[i] = ADDR_W'({$urandom, $urandom});
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 0; i < 4; i++) begin
      khi_pool[i] = {$urandom, $urandom};
      klo_pool[i] = {$urandom, $urandom};
    end
    khi_pool[0] = '0; klo_pool[0] = '1;
    khi_pool[1] = '1; klo_pool[1] = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no local key: add refused, other modes still work
    send_request(make_request(MODE_ADD, 0, 0));
    send_request(make_request(MODE_REMOVE, 0, 0));
    it = make_request(MODE_RECORD, 1, 0);
    it.identity_valid = 1'b0;
    send_request(it);
    send_request(make_request(MODE_LOOKUP, 1, 0));
    send_request(make_request(MODE_LOOKUP, 2, 0));
    send_request(make_request(3'd5, 0, 0));
    send_request(make_request(3'd7, 1, 1));
    set_local_key(1'b1);
    // fill the table past full, duplicates, record more lines than fit
    for (int i = 0; i < 17; i++) begin
      it = make_request(MODE_ADD, i % 8, i / 8);
      it.peer_type = i[0];
      if (i == 16) it.address_in = '1;
      send_request(it);
    end
    send_request(make_request(MODE_ADD, 0, 0));
    for (int i = 0; i < 10; i++) begin
      it = make_request(MODE_RECORD, i % 8, 0);
      it.identity_valid = i != 3;
      send_request(it);
    end
    send_request(make_request(MODE_LOOKUP, 2, 0));
    send_request(make_request(MODE_REMOVE, 2, 0));
    send_request(make_request(MODE_CLEAR, 0, 0));
    send_request(make_request(MODE_LOOKUP, 3, 0));

    for (int phase = 0; phase < 4; phase++) begin
      set_local_key(phase != 2);
      repeat (270) send_request(random_request());
    end

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("%0d beats sent, %0d results checked across add, remove, clear, lookup, record",
             beats_sent, results_seen);
    $display("and unused modes, with the local key toggled between phases");
    if (fail_count == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
